// File: sv/erc_pkg.sv
// shared types, codes and constants for the rx ring consumer
// no dependencies; imported by every module of the block
package erc_pkg;

  // default geometry
  localparam int RING_BYTES_DEF  = 8192;
  localparam int QUEUE_SLOTS_DEF = 8;

  // field widths
  localparam int CFG_W    = 12;
  localparam int OFFOUT_W = 13;
  localparam int SLOT_W   = 3;
  localparam int FLEN_W   = 11;
  localparam int CNT_W    = 32;

  // header checks and ring arithmetic
  localparam logic [15:0]      STATUS_ERR_MASK = 16'h003E;
  localparam logic [15:0]      RP_BACKOFF      = 16'd16;
  localparam logic [15:0]      HDR_BYTES       = 16'd4;
  localparam logic [15:0]      CSUM_BYTES      = 16'd4;
  localparam logic [CFG_W-1:0] WIRE_FLOOR      = 12'd4;
  localparam logic [CFG_W-1:0] WIRE_CEIL       = 12'd2048;
  localparam logic [CFG_W-1:0] MIN_WIRE_RST    = 12'd64;
  localparam logic [CFG_W-1:0] MAX_WIRE_RST    = 12'd1522;

  // config register indexes
  localparam logic [0:0] CFG_MIN_WIRE = 1'b0;
  localparam logic [0:0] CFG_MAX_WIRE = 1'b1;

  // request kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_DEQUEUE = 1'b1;

  typedef enum logic [2:0] {
    OC_QUEUED     = 3'd0,
    OC_BAD_STATUS = 3'd1,
    OC_QUEUE_FULL = 3'd2,
    OC_RING_RESET = 3'd3,
    OC_DEQUEUED   = 3'd4,
    OC_EMPTY      = 3'd5,
    OC_TOO_SMALL  = 3'd6
  } outcome_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] stat_word;
    logic [15:0] entry_len;
    logic [15:0] capacity;
  } req_t;

  typedef struct packed {
    outcome_t              outcome;
    logic [OFFOUT_W-1:0]   ring_offset_out;
    logic [15:0]           read_pointer_out;
    logic [SLOT_W-1:0]     slot_index;
    logic [FLEN_W-1:0]     payload_len;
    logic [SLOT_W-1:0]     queue_depth;
    logic [SLOT_W-1:0]     high_water_out;
    logic [CNT_W-1:0]      packets_count;
    logic [CNT_W-1:0]      errors_count;
    logic [CNT_W-1:0]      dropped_count;
    logic [CNT_W-1:0]      queue_drop_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WRAP,
    ST_DEQ,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request word
    logic eval;    // classify header, update queue and counters
    logic wrap;    // subtract ring size from offset accumulator
    logic commit;  // store new offset, read pointer, high water
    logic deq;     // dequeue decision
    logic emit;    // load response register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_over;  // accumulator still at or above ring size
  } ctrl_sts_t;

endpackage

// File: sv/ethernet_rx_ring_consumer.sv
// top level of the rx ring consumer: controller plus datapath
// depends on erc_pkg, erc_ctrl, erc_dpath
//
//   channel  | handshake               | word
//   ---------+-------------------------+-------------------------------
//   req      | req_valid / req_stall   | erc_pkg::req_t, header or dequeue
//   rsp      | rsp_valid / rsp_stall   | erc_pkg::rsp_t, one per request
//   cfg      | cfg_we                  | cfg_index, cfg_data (12 bit)
//
// header word: capture, classify, k ring-size subtractions in the offset wrap
// (0 or 1 at the default ring), commit, finish; dequeue word: capture, decide,
// finish
// reset is synchronous; no clearing pass, queue slots are read only once written
// one word in flight; a new request is taken while the last response still waits
// on rsp_stall, and the finish step holds until the response register frees up
module ethernet_rx_ring_consumer #(
  parameter int RING_BYTES  = erc_pkg::RING_BYTES_DEF,
  parameter int QUEUE_SLOTS = erc_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  erc_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output erc_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [erc_pkg::CFG_W-1:0] cfg_data
);
  import erc_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: idle, header classify, offset wrap loop, dequeue, finish
  erc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring offset, length queue, counters, response register
  erc_dpath #(
    .RING_BYTES  (RING_BYTES),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

// File: sv/erc_ctrl.sv
// sequencing state machine for the rx ring consumer
// depends on erc_pkg; drives erc_dpath through ctrl_cmd_t
module erc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_kind,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  erc_pkg::ctrl_sts_t sts,
  output erc_pkg::ctrl_cmd_t cmd
);
  import erc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = (req_kind == KIND_DEQUEUE) ? ST_DEQ : ST_EVAL;
        end
      end
      ST_EVAL: state_next = ST_WRAP;
      ST_WRAP: begin
        if (!sts.acc_over) begin
          state_next = ST_DONE;
        end
      end
      ST_DEQ:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.load   = req_valid;
      ST_EVAL: cmd.eval   = 1'b1;
      ST_WRAP: begin
        cmd.wrap   = sts.acc_over;
        cmd.commit = !sts.acc_over;
      end
      ST_DEQ:  cmd.deq    = 1'b1;
      ST_DONE: cmd.emit   = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second word accepted while one is in progress");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> rsp_valid)
    else $error("emitted response not presented");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.eval, cmd.wrap, cmd.commit, cmd.deq, cmd.emit}))
    else $error("more than one datapath command at once");

endmodule

// File: sv/erc_dpath.sv
// datapath: config, ring offset, length queue, counters, response register
// depends on erc_pkg; sequenced by erc_ctrl
module erc_dpath #(
  parameter int RING_BYTES  = erc_pkg::RING_BYTES_DEF,
  parameter int QUEUE_SLOTS = erc_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [erc_pkg::CFG_W-1:0] cfg_data,
  input  erc_pkg::req_t             req,
  input  erc_pkg::ctrl_cmd_t        cmd,
  output erc_pkg::ctrl_sts_t        sts,
  output erc_pkg::rsp_t             rsp
);
  import erc_pkg::*;

  localparam int OFF_W = $clog2(RING_BYTES);
  localparam int ACC_W = OFF_W + 2;
  localparam int PTR_W = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
  localparam logic [ACC_W-1:0] RING_SIZE = ACC_W'(RING_BYTES);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_SLOTS - 1);

  // config
  logic [CFG_W-1:0] min_wire_len;
  logic [CFG_W-1:0] max_wire_len;

  // ring and queue state
  logic [OFF_W-1:0]  ring_offset;
  logic [15:0]       read_pointer;
  logic [PTR_W-1:0]  queue_head;
  logic [PTR_W-1:0]  queue_tail;
  logic [PTR_W-1:0]  high_water;
  logic [CNT_W-1:0]  packets;
  logic [CNT_W-1:0]  errors;
  logic [CNT_W-1:0]  dropped;
  logic [CNT_W-1:0]  queue_drops;

  // per-word working registers
  req_t              cur;
  logic [ACC_W-1:0]  acc;
  outcome_t          outcome;
  logic [PTR_W-1:0]  slot;
  logic [FLEN_W-1:0] flen;

  // length queue storage
  logic [FLEN_W-1:0] slot_mem [QUEUE_SLOTS];
  logic [FLEN_W-1:0] head_len;

  logic [CFG_W-1:0]  lo_bound;
  logic [CFG_W-1:0]  hi_bound;
  logic              bad_len;
  logic              bad_status;
  logic [PTR_W-1:0]  tail_inc;
  logic [PTR_W-1:0]  head_inc;
  logic              q_full;
  logic              q_empty;
  logic [PTR_W:0]    depth_wide;
  logic [PTR_W-1:0]  depth;
  logic [ACC_W-1:0]  adv_sum;
  logic [ACC_W-1:0]  adv_aligned;
  logic [FLEN_W-1:0] push_len;

  assign lo_bound   = (min_wire_len < WIRE_FLOOR) ? WIRE_FLOOR : min_wire_len;
  assign hi_bound   = (max_wire_len > WIRE_CEIL) ? WIRE_CEIL : max_wire_len;
  assign bad_len    = (cur.entry_len < {4'd0, lo_bound}) ||
                      (cur.entry_len > {4'd0, hi_bound});
  assign bad_status = !cur.stat_word[0] || ((cur.stat_word & STATUS_ERR_MASK) != '0);

  assign tail_inc = (queue_tail == PTR_LAST) ? '0 : queue_tail + 1'b1;
  assign head_inc = (queue_head == PTR_LAST) ? '0 : queue_head + 1'b1;
  assign q_full   = (tail_inc == queue_head);
  assign q_empty  = (queue_head == queue_tail);

  assign depth_wide = {1'b0, queue_tail} + (PTR_W+1)'(QUEUE_SLOTS) - {1'b0, queue_head};
  assign depth      = (queue_tail >= queue_head) ? (queue_tail - queue_head)
                                                 : depth_wide[PTR_W-1:0];

  // only used once the length is inside bounds, so 12 bits of length suffice
  assign adv_sum     = ACC_W'(ring_offset) + ACC_W'(HDR_BYTES) +
                       ACC_W'(cur.entry_len[11:0]) + ACC_W'(3);
  assign adv_aligned = {adv_sum[ACC_W-1:2], 2'b00};
  assign push_len    = FLEN_W'(cur.entry_len - CSUM_BYTES);

  assign sts.acc_over = (acc >= RING_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_wire_len <= MIN_WIRE_RST;
      max_wire_len <= MAX_WIRE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_WIRE: min_wire_len <= cfg_data;
        CFG_MAX_WIRE: max_wire_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // queue storage, registered read of the head slot
  always_ff @(posedge clk) begin
    if (cmd.eval && !bad_len && !bad_status && !q_full) begin
      slot_mem[queue_tail] <= push_len;
    end
    head_len <= slot_mem[queue_head];
  end

  // payload working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.eval) begin
      if (bad_len) begin
        outcome <= OC_RING_RESET;
        acc     <= '0;
        slot    <= '0;
        flen    <= '0;
      end else begin
        acc <= adv_aligned;
        if (bad_status) begin
          outcome <= OC_BAD_STATUS;
          slot    <= '0;
          flen    <= '0;
        end else if (q_full) begin
          outcome <= OC_QUEUE_FULL;
          slot    <= '0;
          flen    <= '0;
        end else begin
          outcome <= OC_QUEUED;
          slot    <= queue_tail;
          flen    <= push_len;
        end
      end
    end else if (cmd.wrap) begin
      acc <= acc - RING_SIZE;
    end
    if (cmd.deq) begin
      if (q_empty) begin
        outcome <= OC_EMPTY;
        slot    <= '0;
        flen    <= '0;
      end else begin
        slot    <= queue_head;
        flen    <= head_len;
        outcome <= (cur.capacity < {5'd0, head_len}) ? OC_TOO_SMALL : OC_DEQUEUED;
      end
    end
    if (cmd.emit) begin
      rsp.outcome          <= outcome;
      rsp.ring_offset_out  <= OFFOUT_W'(ring_offset);
      rsp.read_pointer_out <= read_pointer;
      rsp.slot_index       <= SLOT_W'(slot);
      rsp.payload_len      <= flen;
      rsp.queue_depth      <= SLOT_W'(depth);
      rsp.high_water_out   <= SLOT_W'(high_water);
      rsp.packets_count    <= packets;
      rsp.errors_count     <= errors;
      rsp.dropped_count    <= dropped;
      rsp.queue_drop_count <= queue_drops;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_offset  <= '0;
      read_pointer <= '0 - RP_BACKOFF;
      queue_head   <= '0;
      queue_tail   <= '0;
      high_water   <= '0;
      packets      <= '0;
      errors       <= '0;
      dropped      <= '0;
      queue_drops  <= '0;
    end else begin
      if (cmd.eval) begin
        if (bad_len || bad_status) begin
          errors  <= errors + 1'b1;
          dropped <= dropped + 1'b1;
        end else if (q_full) begin
          queue_drops <= queue_drops + 1'b1;
          dropped     <= dropped + 1'b1;
        end else begin
          queue_tail <= tail_inc;
          packets    <= packets + 1'b1;
        end
      end
      // offset zero on a ring reset gives the initial read pointer too
      if (cmd.commit) begin
        ring_offset  <= acc[OFF_W-1:0];
        read_pointer <= 16'(acc) - RP_BACKOFF;
        if (depth > high_water) begin
          high_water <= depth;
        end
      end
      if (cmd.deq && !q_empty && !(cur.capacity < {5'd0, head_len})) begin
        queue_head <= head_inc;
      end
    end
  end

  a_commit_in_ring: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (acc < RING_SIZE))
    else $error("ring offset committed outside the ring");

  a_high_water: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (high_water >= depth))
    else $error("high water below current depth at response");

  a_never_overfull: assert property (@(posedge clk) disable iff (rst)
    $past(q_full) && $past(cmd.eval) |-> (queue_tail == $past(queue_tail)))
    else $error("tail moved on a full queue");

endmodule
